// ===== sv/lprt_pkg.sv =====
// lprt_pkg.sv: shared types, codes and sizing constants for the linear-probe route table
`timescale 1ns / 1ps

package lprt_pkg;

	// table sizing (slot count must be a power of two)
	localparam int unsigned TABLE_SLOTS = 1024;
	localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int unsigned OCC_W       = SLOT_W + 1;

	// load limit: a new key goes in only while occupancy * 10 < slots * 7
	localparam int unsigned LOAD_NUM   = 10;
	localparam int unsigned LOAD_DEN   = 7;
	localparam logic [OCC_W-1:0] LOAD_LIMIT =
		OCC_W'((TABLE_SLOTS * LOAD_DEN + LOAD_NUM - 1) / LOAD_NUM);

	// hash multiplier, only the low slot bits of the product are needed
	localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
	localparam logic [SLOT_W-1:0] HASH_MULT_LO = HASH_MULT[SLOT_W-1:0];
	localparam int unsigned HASH_SHIFT = 32;

	// opcodes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_GET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// request and result transactions
	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] key;
		logic [31:0] route_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_value;
	} res_t;

	// slot index source for the next cycle
	typedef enum logic [1:0] {
		IDX_HOLD = 2'd0,
		IDX_HASH = 2'd1,
		IDX_NEXT = 2'd2,
		IDX_ZERO = 2'd3
	} idx_sel_t;

	// controller to datapath
	typedef struct packed {
		logic       load;       // capture the request
		idx_sel_t   idx_sel;
		logic       wr_key;     // write key memory at current slot
		logic       key_zero;   // written key is zero (clear sweep)
		logic       wr_val;     // write value memory at current slot
		logic       occ_inc;
		logic       occ_clr;
		logic       finish;     // register a result
		logic [1:0] status;
		logic       use_found;  // result carries the stored value
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad_put;    // zero key or zero value
		logic empty;      // slot under probe is empty
		logic match;      // slot under probe holds the key
		logic bound;      // last slot of the probe bound
		logic at_limit;   // occupancy has reached the load limit
		logic last_slot;  // current slot is the final one of the table
	} sts_t;

endpackage

// ===== sv/linear_probe_route_table.sv =====
// linear_probe_route_table.sv: top level of the open-addressing route table
//
//   channel   direction  handshake                      payload
//   request   in         start high while busy low      req_t: opcode, key, route_value
//   result    out        done high for one cycle        res_t: status, found_value
//
// A put or get is captured and hashed, then walks the slots, reading one key memory
// entry per cycle; its result is registered when the walk ends (a rejected put or an unused opcode ends after capture).
// A clear sweeps every slot from slot 0, one per cycle, then registers its result.
// After reset the same sweep runs with busy high and no result.
// A new request may be accepted in the cycle that shows done; results cannot be held off.
`timescale 1ns / 1ps

module linear_probe_route_table
	import lprt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output res_t result
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	lprt_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (request.opcode),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// storage and arithmetic
	lprt_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

endmodule

// ===== sv/lprt_datapath.sv =====
// lprt_datapath.sv: key and value memories, hash, probe index, occupancy and result register
`timescale 1ns / 1ps

module lprt_datapath
	import lprt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        request,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        done,
	output res_t        result
);

	logic [63:0]       slot_keys   [TABLE_SLOTS];
	logic [31:0]       slot_values [TABLE_SLOTS];

	logic [63:0]       key_q;
	logic [31:0]       val_q;
	logic [SLOT_W-1:0] hash_s1;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] nxt_idx;
	logic [SLOT_W-1:0] cnt_q;
	logic [OCC_W-1:0]  occ_q;
	logic [63:0]       rkey_q;
	logic [31:0]       rval_q;
	logic [2*SLOT_W-1:0] prod;
	logic              done_q;
	res_t              res_q;

	// low slot bits of the hash product
	assign prod = request.key[SLOT_W-1:0] * HASH_MULT_LO;

	// request capture and first hash stage
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q   <= request.key;
			val_q   <= request.route_value;
			hash_s1 <= prod[SLOT_W-1:0];
		end
	end

	// next slot index
	always_comb begin
		case (cmd.idx_sel)
			IDX_HASH: nxt_idx = hash_s1 ^ key_q[HASH_SHIFT +: SLOT_W];
			IDX_NEXT: nxt_idx = idx_q + 1'b1;
			IDX_ZERO: nxt_idx = '0;
			default:  nxt_idx = idx_q;
		endcase
	end

	// slot index and probe count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			idx_q <= nxt_idx;
			if (cmd.idx_sel == IDX_HASH) begin
				cnt_q <= '0;
			end else if (cmd.idx_sel == IDX_NEXT) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// key memory: one write port at the current slot, registered read at the next
	always_ff @(posedge clk) begin
		if (cmd.wr_key) begin
			slot_keys[idx_q] <= cmd.key_zero ? 64'd0 : key_q;
		end
		rkey_q <= slot_keys[nxt_idx];
	end

	// value memory
	always_ff @(posedge clk) begin
		if (cmd.wr_val) begin
			slot_values[idx_q] <= val_q;
		end
		rval_q <= slot_values[nxt_idx];
	end

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.occ_clr) begin
			occ_q <= '0;
		end else if (cmd.occ_inc) begin
			occ_q <= occ_q + 1'b1;
		end
	end

	// status toward the controller
	always_comb begin
		sts.bad_put   = (key_q == 64'd0) || (val_q == 32'd0);
		sts.empty     = (rkey_q == 64'd0);
		sts.match     = (rkey_q == key_q);
		sts.bound     = &cnt_q;
		sts.at_limit  = (occ_q >= LOAD_LIMIT);
		sts.last_slot = &idx_q;
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.status      <= cmd.status;
			res_q.found_value <= cmd.use_found ? rval_q : 32'd0;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== sv/lprt_controller.sv =====
// lprt_controller.sv: sequencing state machine for put, get, clear and the reset sweep
`timescale 1ns / 1ps

module lprt_controller
	import lprt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] opcode,
	input  sts_t       sts,
	output logic       busy,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_LOAD  = 4'b0010,
		S_PROBE = 4'b0100,
		S_CLEAR = 4'b1000
	} state_t;

	state_t     state_q, state_nxt;
	logic [1:0] op_q;
	logic       report_q;
	logic       accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// state, opcode and clear-report flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			op_q     <= OP_NONE;
			report_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				op_q     <= opcode;
				report_q <= 1'b1;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		cmd.idx_sel   = IDX_HOLD;
		cmd.status    = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (opcode == OP_CLEAR) begin
						cmd.idx_sel = IDX_ZERO;
						state_nxt   = S_CLEAR;
					end else begin
						state_nxt = S_LOAD;
					end
				end
			end
			S_LOAD: begin
				if ((op_q == OP_PUT && sts.bad_put) || op_q == OP_NONE) begin
					cmd.finish = 1'b1;
					cmd.status = (op_q == OP_PUT) ? ST_REJECT : ST_OK;
					state_nxt  = S_IDLE;
				end else begin
					cmd.idx_sel = IDX_HASH;
					state_nxt   = S_PROBE;
				end
			end
			S_PROBE: begin
				if (sts.empty) begin
					// key absent, first free slot found
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
					if (op_q == OP_PUT) begin
						if (sts.at_limit) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.wr_key  = 1'b1;
							cmd.wr_val  = 1'b1;
							cmd.occ_inc = 1'b1;
						end
					end
				end else if (sts.match) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
					if (op_q == OP_PUT) begin
						cmd.wr_val = 1'b1;
					end else begin
						cmd.use_found = 1'b1;
					end
				end else if (sts.bound) begin
					// whole table walked without a free slot
					cmd.finish = 1'b1;
					cmd.status = (op_q == OP_PUT) ? ST_FULL : ST_OK;
					state_nxt  = S_IDLE;
				end else begin
					cmd.idx_sel = IDX_NEXT;
				end
			end
			S_CLEAR: begin
				// sweep: zero one key slot per cycle
				cmd.wr_key   = 1'b1;
				cmd.key_zero = 1'b1;
				cmd.occ_clr  = 1'b1;
				cmd.idx_sel  = IDX_NEXT;
				if (sts.last_slot) begin
					cmd.finish = report_q;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/lprt_checker.sv =====
// lprt_checker.sv: port-level checks on the route table, bound to the top level
`timescale 1ns / 1ps

module lprt_checker
	import lprt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t request,
	input logic done,
	input res_t result
);

	// a result only follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// results never come in adjacent cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// an accepted transaction makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a transaction");

	// a put with zero key is rejected right away
	a_zero_key_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.opcode == OP_PUT && request.key == 64'd0)
		|-> ##2 (done && result.status == ST_REJECT && result.found_value == 32'd0))
		else $error("zero-key put not rejected");

	// a result with a reject or full status carries a zero found_value
	a_full_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.found_value == 32'd0))
		else $error("value returned with a non-ok status");

endmodule

bind linear_probe_route_table lprt_checker u_lprt_checker (.*);

// ===== test/linear_probe_route_table_test.sv =====
// linear_probe_route_table_test.sv: self-checking testbench for the linear-probe route table
`timescale 1ns / 1ps

module linear_probe_route_table_test;
	import lprt_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic done;
	res_t result;

	linear_probe_route_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// requests waiting to go out and results still owed by the block
	req_t pending_requests[$];
	res_t expected_results[$];
	logic [63:0] recent_keys[$];
	res_t oldest_expected;

	int sender_idle_pct = 0;
	int queued_count = 0;
	int accepted_count = 0;
	int error_count = 0;

	// shadow copy of the table
	logic [63:0] shadow_keys[TABLE_SLOTS];
	logic [31:0] shadow_values[TABLE_SLOTS];
	int unsigned shadow_occupancy = 0;
	int unsigned peak_occupancy = 0;

	// coverage tallies for the closing summary
	int put_count = 0;
	int get_count = 0;
	int clear_count = 0;
	int unused_count = 0;
	int full_count = 0;
	int reject_count = 0;
	int hit_count = 0;

	// start slot of a key: upper half xor the multiplied key, low slot bits
	function automatic logic [SLOT_W-1:0] home_slot(input logic [63:0] k);
		logic [63:0] mixed;
		mixed = (k >> HASH_SHIFT) ^ (k * HASH_MULT);
		return mixed[SLOT_W-1:0];
	endfunction

	// walk the probe chain: stop at the key or at the first empty slot
	function automatic void find_slot(input logic [63:0] k, output logic [SLOT_W-1:0] idx,
			output bit hit, output bit has_gap);
		int n;
		idx = home_slot(k);
		hit = 1'b0;
		has_gap = 1'b0;
		for (n = 0; n < TABLE_SLOTS; n++) begin
			if (shadow_keys[idx] == '0) begin
				has_gap = 1'b1;
				return;
			end
			if (shadow_keys[idx] == k) begin
				hit = 1'b1;
				return;
			end
			idx = idx + 1'b1;
		end
	endfunction

	// expected result of one transaction, updating the shadow table
	function automatic res_t predict_route_result(input req_t req);
		res_t res;
		logic [SLOT_W-1:0] idx;
		bit hit;
		bit has_gap;
		res.status = ST_OK;
		res.found_value = '0;
		case (req.opcode)
			OP_PUT: begin
				put_count++;
				if (req.key == '0 || req.route_value == '0) begin
					res.status = ST_REJECT;
					reject_count++;
				end else begin
					find_slot(req.key, idx, hit, has_gap);
					if (hit) begin
						shadow_values[idx] = req.route_value;
					end else if (shadow_occupancy * LOAD_NUM >= TABLE_SLOTS * LOAD_DEN
							|| !has_gap) begin
						res.status = ST_FULL;
						full_count++;
					end else begin
						shadow_keys[idx] = req.key;
						shadow_values[idx] = req.route_value;
						shadow_occupancy++;
						if (shadow_occupancy > peak_occupancy)
							peak_occupancy = shadow_occupancy;
					end
				end
			end
			OP_GET: begin
				get_count++;
				if (req.key != '0) begin
					find_slot(req.key, idx, hit, has_gap);
					if (hit) begin
						res.found_value = shadow_values[idx];
						hit_count++;
					end
				end
			end
			OP_CLEAR: begin
				clear_count++;
				foreach (shadow_keys[i])
					shadow_keys[i] = '0;
				shadow_occupancy = 0;
			end
			default: begin
				unused_count++;
			end
		endcase
		return res;
	endfunction

	// driver: present the next request, hold it until the block takes it
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(predict_route_result(request));
				accepted_count++;
			end
			if (!start || !busy) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					request <= pending_requests.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobed result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no transaction outstanding: status %0d, found_value %0h",
					result.status, result.found_value);
				error_count++;
			end else begin
				oldest_expected = expected_results.pop_front();
				if (result.status !== oldest_expected.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						oldest_expected.status, result.status);
					error_count++;
				end
				if (result.found_value !== oldest_expected.found_value) begin
					$error("found_value mismatch: expected %0h, actual %0h",
						oldest_expected.found_value, result.found_value);
					error_count++;
				end
			end
		end
	end

	// queue one transaction, remembering the keys of recent puts for later hits
	task automatic queue_op(input logic [1:0] op, input logic [63:0] k, input logic [31:0] v);
		req_t req;
		req.opcode = op;
		req.key = k;
		req.route_value = v;
		pending_requests.push_back(req);
		queued_count++;
		if (op == OP_PUT && k != '0) begin
			recent_keys.push_back(k);
			if (recent_keys.size() > 96)
				void'(recent_keys.pop_front());
		end
	endtask

	// a key seen before, or a fresh random one
	function automatic logic [63:0] pick_key(input int reuse_pct);
		if (recent_keys.size() != 0 && $urandom_range(99) < reuse_pct)
			return recent_keys[$urandom_range(recent_keys.size() - 1)];
		return {$urandom, $urandom};
	endfunction

	// random mix of puts, gets, rare clears and unused opcodes
	task automatic queue_mixed_ops(input int count);
		int sel;
		logic [63:0] k;
		logic [31:0] v;
		repeat (count) begin
			sel = $urandom_range(99);
			k = pick_key(55);
			v = $urandom;
			if ($urandom_range(24) == 0)
				k = '0;
			if ($urandom_range(24) == 0)
				v = '0;
			if (sel < 48)
				queue_op(OP_PUT, k, v);
			else if (sel < 94)
				queue_op(OP_GET, k, v);
			else if (sel < 96)
				queue_op(OP_CLEAR, k, v);
			else
				queue_op(OP_NONE, k, v);
		end
	endtask

	// wait until every queued transaction is taken and answered
	task automatic drain();
		while (pending_requests.size() != 0 || accepted_count != queued_count
				|| expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// reset, then the stimulus phases
	initial begin
		logic [63:0] wrap_keys[4];
		logic [31:0] v;
		int i;
		int sel;

		// shadow table starts empty, as the block does after reset
		foreach (shadow_keys[j])
			shadow_keys[j] = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// keys whose probe starts in the last slot, so the chain wraps to slot 0
		for (i = 0; i < 4; i++) begin
			do
				wrap_keys[i] = {$urandom, $urandom};
			while (home_slot(wrap_keys[i]) != SLOT_W'(TABLE_SLOTS - 1) || wrap_keys[i] == '0
				|| (i > 0 && wrap_keys[i] == wrap_keys[i-1]));
		end

		// directed: empty table, rejects, extremes, overwrite, wrap, clear
		queue_op(OP_GET, 64'h1, 32'h0);
		queue_op(OP_PUT, 64'h0, 32'h5);
		queue_op(OP_PUT, 64'h5, 32'h0);
		queue_op(OP_PUT, 64'h0, 32'h0);
		queue_op(OP_PUT, '1, '1);
		queue_op(OP_GET, '1, '0);
		queue_op(OP_PUT, '1, 32'h1);
		queue_op(OP_GET, '1, '0);
		queue_op(OP_GET, 64'h0, '1);
		queue_op(OP_NONE, '1, '1);
		queue_op(OP_PUT, 64'h8000_0000_0000_0000, 32'h8000_0000);
		for (i = 0; i < 3; i++)
			queue_op(OP_PUT, wrap_keys[i], 32'h100 + i);
		for (i = 0; i < 3; i++)
			queue_op(OP_GET, wrap_keys[i], '0);
		queue_op(OP_GET, wrap_keys[3], '0);
		queue_op(OP_PUT, wrap_keys[1], 32'hA5A5_5A5A);
		queue_op(OP_GET, wrap_keys[1], '0);
		queue_op(OP_CLEAR, '1, '1);
		queue_op(OP_GET, '1, '0);
		queue_op(OP_GET, wrap_keys[2], '0);
		queue_op(OP_PUT, wrap_keys[2], 32'h7FFF_FFFF);
		queue_op(OP_GET, wrap_keys[2], '0);
		drain();

		// fill past the load limit, with lookups along the way
		for (i = 0; i < 740; i++) begin
			v = $urandom;
			if (v == '0)
				v = 32'h1;
			queue_op(OP_PUT, {$urandom, $urandom}, v);
			if ($urandom_range(3) == 0)
				queue_op(OP_GET, pick_key(90), '0);
		end
		// at the limit: overwrites still pass, new keys are refused
		repeat (40) begin
			sel = $urandom_range(3);
			v = $urandom | 32'h1;
			if (sel == 0)
				queue_op(OP_PUT, pick_key(100), v);
			else if (sel == 1)
				queue_op(OP_PUT, {$urandom, $urandom}, v);
			else
				queue_op(OP_GET, pick_key(sel == 2 ? 100 : 0), '0);
		end
		queue_op(OP_CLEAR, '0, '0);
		repeat (8) queue_op(OP_GET, pick_key(100), '0);
		drain();

		// random traffic under different sender gaps
		sender_idle_pct = 61;
		queue_mixed_ops(220);
		drain();
		sender_idle_pct = 0;
		queue_mixed_ops(220);
		drain();
		sender_idle_pct = 28;
		queue_mixed_ops(220);
		drain();

		repeat (32) @(negedge clk);
		$display("covered %0d transactions: %0d put, %0d get, %0d clear, %0d unused opcode",
			accepted_count, put_count, get_count, clear_count, unused_count);
		$display("%0d table full, %0d rejected, %0d get hits, peak occupancy %0d of %0d slots",
			full_count, reject_count, hit_count, peak_occupancy, TABLE_SLOTS);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#200_000_000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
sv/lprt_pkg.sv
sv/lprt_datapath.sv
sv/lprt_controller.sv
sv/linear_probe_route_table.sv
sv/lprt_checker.sv
test/linear_probe_route_table_test.sv
